### rtl/core/mfs_pkg.sv
// shared constants, state type and queue address and index wrap helpers for the feedback scheduler
`timescale 1ns / 1ps
`default_nettype none

package mfs_pkg;

	localparam int MAX_PROCS = 32;
	localparam int LEVELS    = 5;
	localparam int ID_W      = 5;
	localparam int LV_W      = 3;
	localparam int SVC_W     = 16;
	localparam int TIME_W    = 32;
	localparam int IDX_W     = $clog2(MAX_PROCS);
	localparam int CNT_W     = $clog2(MAX_PROCS + 1);
	localparam int QDEPTH    = LEVELS * MAX_PROCS;
	localparam int QA_W      = $clog2(QDEPTH);
	localparam int LEFT_W    = LEVELS;
	localparam int RDY_W     = $clog2(QDEPTH + 2);
	localparam int PMEM_W    = TIME_W + 2 * SVC_W;
	localparam int IN_W      = 24;
	localparam int OUT_W     = 80;

	localparam logic REQ_ARRIVE = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QRD,
		ST_CHK,
		ST_QRD2,
		ST_RUN
	} state_t;

	function automatic logic [QA_W-1:0] qaddr(input logic [LV_W-1:0] lv,
		input logic [IDX_W-1:0] idx);
		qaddr = QA_W'(lv) * QA_W'(MAX_PROCS) + QA_W'(idx);
	endfunction

	function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx);
		wrap_next = (idx == IDX_W'(MAX_PROCS - 1)) ? '0 : idx + 1'b1;
	endfunction

endpackage

`default_nettype wire

### rtl/core/multilevel_feedback_scheduler_top.sv
// multilevel feedback queue scheduler: process table and level queues in memories
//
//  channel | direction | handshake          | payload
//  cfg     | in        | cfg_valid/cfg_ready | cfg_data[0] slice_mode
//  s       | in        | s_tvalid/s_tready  | s_tuser req_type, s_tdata proc_id, service_time
//  m       | out       | m_tvalid/m_tready  | m_tdata tick result
//
// an arrival request and a tick with all queues empty are done in idle; a tick with a slice
// running goes through run, a new pick through qrd then run, the level-0 front check adds chk,
// and a rotated front adds qrd2 after chk (queue memory read latency sets these states)
// reset clears control registers only; memories are read only after being written
// a new request is taken in idle once the result register is free or being drained
`timescale 1ns / 1ps
`default_nettype none

module multilevel_feedback_scheduler_top
	import mfs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	output      logic             cfg_ready,
	input  wire logic [0:0]       cfg_data,
	input  wire logic             s_tvalid,
	output      logic             s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,   // proc_id, service_time, zero pad
	input  wire logic [0:0]       s_tuser,   // req_type
	output      logic             m_tvalid,
	input  wire logic             m_tready,
	output      logic [OUT_W-1:0] m_tdata    // cpu_busy, running_id, run_level, finished,
	                                         // finish_time, turnaround, zero pad
);

	state_t state_q, state_d;

	logic                 mode_q;
	logic [TIME_W-1:0]    clock_q;
	logic [IDX_W-1:0]     head_q [LEVELS];
	logic [IDX_W-1:0]     tail_q [LEVELS];
	logic [CNT_W-1:0]     cnt_q  [LEVELS];
	logic [RDY_W-1:0]     ready_q;
	logic                 act_q;
	logic [ID_W-1:0]      sproc_q;
	logic [LV_W-1:0]      slv_q;
	logic [LEFT_W-1:0]    sleft_q;
	logic [LV_W-1:0]      lv_q;
	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_data_q;

	logic [PMEM_W-1:0]    pmem [MAX_PROCS];
	logic [ID_W-1:0]      qmem [QDEPTH];
	logic [PMEM_W-1:0]    p_rd_q;
	logic [ID_W-1:0]      q_rd_q;

	logic                 p_we, p_re, q_we, q_re;
	logic [IDX_W-1:0]     p_waddr, p_raddr;
	logic [PMEM_W-1:0]    p_wdata;
	logic [QA_W-1:0]      q_waddr, q_raddr;
	logic [ID_W-1:0]      q_wdata;

	logic                 s_fire;
	logic                 in_req;
	logic [ID_W-1:0]      in_id;
	logic [SVC_W-1:0]     in_svc;
	logic                 arr_ok;
	logic                 found;
	logic [LV_W-1:0]      pick_lv;
	logic                 rot_need;
	logic [SVC_W-1:0]     rem_r, svc_r, rem_n;
	logic [TIME_W-1:0]    arr_r, clk_n, turn;
	logic                 rot;
	logic [LEFT_W-1:0]    left_n;
	logic                 done;
	logic                 preempt;
	logic [LV_W-1:0]      slv_nx, push_lv;
	logic                 lower_full;
	logic                 push_room;
	logic                 out_load;
	logic                 count_ok;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign s_fire    = s_tvalid && s_tready;
	assign in_req    = s_tuser[0];
	assign in_id     = s_tdata[ID_W-1:0];
	assign in_svc    = s_tdata[ID_W+SVC_W-1:ID_W];
	assign arr_ok    = (in_svc != '0) && (cnt_q[0] < CNT_W'(MAX_PROCS));
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	// highest priority nonempty level (lowest index)
	always_comb begin
		found   = 1'b0;
		pick_lv = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (cnt_q[i] != '0) begin
				found   = 1'b1;
				pick_lv = LV_W'(i);
			end
		end
	end

	assign rot_need = (lv_q == '0) && (cnt_q[0] > CNT_W'(1));
	assign rem_r    = p_rd_q[SVC_W-1:0];
	assign svc_r    = p_rd_q[2*SVC_W-1:SVC_W];
	assign arr_r    = p_rd_q[PMEM_W-1:2*SVC_W];
	assign rot      = rem_r < svc_r;
	assign rem_n    = (rem_r != '0) ? rem_r - 1'b1 : '0;
	assign clk_n    = clock_q + 1'b1;
	assign turn     = clk_n - arr_r;
	assign left_n   = sleft_q - 1'b1;
	assign done     = (rem_n == '0);
	assign preempt  = !done && (left_n == '0);
	assign slv_nx   = slv_q + 1'b1;
	assign lower_full = (slv_q == LV_W'(LEVELS - 1)) || (cnt_q[slv_nx] == CNT_W'(MAX_PROCS));
	assign push_lv  = ((ready_q == RDY_W'(1)) || lower_full) ? slv_q : slv_nx;
	// with no room at the chosen push level the preempted process is dropped
	assign push_room = (cnt_q[push_lv] != CNT_W'(MAX_PROCS));
	assign out_load = (state_q == ST_RUN) ||
		((state_q == ST_IDLE) && s_fire && (in_req == REQ_TICK) && !act_q && !found);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_fire && in_req == REQ_TICK) begin
					if (act_q)
						state_d = ST_RUN;
					else if (found)
						state_d = ST_QRD;
				end
			end
			ST_QRD:  state_d = rot_need ? ST_CHK : ST_RUN;
			ST_CHK:  state_d = rot ? ST_QRD2 : ST_RUN;
			ST_QRD2: state_d = ST_RUN;
			ST_RUN:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		p_we    = 1'b0;
		p_re    = 1'b0;
		q_we    = 1'b0;
		q_re    = 1'b0;
		p_waddr = '0;
		p_raddr = '0;
		p_wdata = '0;
		q_waddr = '0;
		q_raddr = '0;
		q_wdata = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					if (in_req == REQ_ARRIVE) begin
						if (arr_ok) begin
							p_we    = 1'b1;
							p_waddr = IDX_W'(in_id);
							p_wdata = {clock_q, in_svc, in_svc};
							q_we    = 1'b1;
							q_waddr = qaddr('0, tail_q[0]);
							q_wdata = in_id;
						end
					end else if (act_q) begin
						p_re    = 1'b1;
						p_raddr = IDX_W'(sproc_q);
					end else if (found) begin
						q_re    = 1'b1;
						q_raddr = qaddr(pick_lv, head_q[pick_lv]);
					end
				end
			end
			ST_QRD: begin
				p_re    = 1'b1;
				p_raddr = IDX_W'(q_rd_q);
			end
			ST_CHK: begin
				if (rot) begin
					// front already ran: move it to the back, fetch the next one
					q_we    = 1'b1;
					q_waddr = qaddr('0, tail_q[0]);
					q_wdata = q_rd_q;
					q_re    = 1'b1;
					q_raddr = qaddr('0, wrap_next(head_q[0]));
				end
			end
			ST_QRD2: begin
				p_re    = 1'b1;
				p_raddr = IDX_W'(q_rd_q);
			end
			ST_RUN: begin
				p_we    = 1'b1;
				p_waddr = IDX_W'(sproc_q);
				p_wdata = {arr_r, svc_r, rem_n};
				if (preempt && push_room) begin
					q_we    = 1'b1;
					q_waddr = qaddr(push_lv, tail_q[push_lv]);
					q_wdata = sproc_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (p_we)
			pmem[p_waddr] <= p_wdata;
		if (p_re)
			p_rd_q <= pmem[p_raddr];
		if (q_we)
			qmem[q_waddr] <= q_wdata;
		if (q_re)
			q_rd_q <= qmem[q_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= 1'b0;
			clock_q     <= '0;
			ready_q     <= '0;
			act_q       <= 1'b0;
			sproc_q     <= '0;
			slv_q       <= '0;
			sleft_q     <= '0;
			lv_q        <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready)
				mode_q <= cfg_data[0];
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						if (in_req == REQ_ARRIVE) begin
							if (arr_ok) begin
								tail_q[0] <= wrap_next(tail_q[0]);
								cnt_q[0]  <= cnt_q[0] + 1'b1;
								ready_q   <= ready_q + 1'b1;
							end
						end else if (!act_q) begin
							if (found) begin
								lv_q <= pick_lv;
							end else begin
								clock_q     <= clk_n;
								out_data_q  <= OUT_W'({TIME_W'(0), clk_n, 1'b0,
									LV_W'(0), ID_W'(0), 1'b0});
							end
						end
					end
				end
				ST_QRD: begin
					if (!rot_need) begin
						head_q[lv_q] <= wrap_next(head_q[lv_q]);
						cnt_q[lv_q]  <= cnt_q[lv_q] - 1'b1;
						sproc_q      <= q_rd_q;
						slv_q        <= lv_q;
						sleft_q      <= mode_q ? (LEFT_W'(1) << lv_q) : LEFT_W'(1);
						act_q        <= 1'b1;
					end
				end
				ST_CHK: begin
					if (rot) begin
						head_q[0] <= wrap_next(head_q[0]);
						tail_q[0] <= wrap_next(tail_q[0]);
					end else begin
						head_q[0] <= wrap_next(head_q[0]);
						cnt_q[0]  <= cnt_q[0] - 1'b1;
						sproc_q   <= q_rd_q;
						slv_q     <= '0;
						sleft_q   <= LEFT_W'(1);
						act_q     <= 1'b1;
					end
				end
				ST_QRD2: begin
					head_q[0] <= wrap_next(head_q[0]);
					cnt_q[0]  <= cnt_q[0] - 1'b1;
					sproc_q   <= q_rd_q;
					slv_q     <= '0;
					sleft_q   <= LEFT_W'(1);
					act_q     <= 1'b1;
				end
				ST_RUN: begin
					clock_q <= clk_n;
					sleft_q <= left_n;
					if (done) begin
						act_q <= 1'b0;
						if (ready_q != '0)
							ready_q <= ready_q - 1'b1;
					end else if (left_n == '0) begin
						act_q <= 1'b0;
						if (push_room) begin
							tail_q[push_lv] <= wrap_next(tail_q[push_lv]);
							cnt_q[push_lv]  <= cnt_q[push_lv] + 1'b1;
						end
					end
					out_data_q  <= OUT_W'({done ? turn : TIME_W'(0), clk_n, done,
						slv_q, sproc_q, 1'b1});
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		count_ok = 1'b1;
		for (int i = 0; i < LEVELS; i++)
			if (cnt_q[i] > CNT_W'(MAX_PROCS))
				count_ok = 1'b0;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n) count_ok)
		else $error("queue count above capacity");

	a_run_returns: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |=> state_q == ST_IDLE)
		else $error("run state not followed by idle");

	a_run_active: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> act_q)
		else $error("slice executed without an active slice");

	a_result_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> (!out_valid_q || m_tready))
		else $error("result register overwritten");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == ST_IDLE)
		else $error("request taken outside idle");

endmodule

`default_nettype wire

### verif/tb.sv
// self-checking testbench for the multilevel feedback scheduler
`timescale 1ns / 1ps
`default_nettype none

module tb;
	import mfs_pkg::*;

	// lowest field in the lowest bits, as on m_tdata
	typedef struct packed {
		logic [31:0] tat;
		logic [31:0] ftime;
		logic        done;
		logic [2:0]  lvl;
		logic [4:0]  pid;
		logic        busy;
	} tick_res_t;

	typedef struct {
		logic        kind;
		logic [4:0]  pid;
		logic [15:0] svc;
		logic        has_exp;
		tick_res_t   exp;
	} stim_t;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [0:0] cfg_data;
	logic s_tvalid, s_tready;
	logic [IN_W-1:0] s_tdata;
	logic [0:0] s_tuser;
	logic m_tvalid, m_tready;
	logic [OUT_W-1:0] m_tdata;

	multilevel_feedback_scheduler_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// predictor state
	logic [31:0] now;
	logic [15:0] rem_t [MAX_PROCS];
	logic [15:0] svc_len [MAX_PROCS];
	logic [31:0] stamp [MAX_PROCS];
	logic [4:0]  lq [LEVELS][$];
	int          n_ready;
	logic        running;
	logic [4:0]  run_pid;
	int          run_lvl;
	int          run_left;
	logic        mode;

	tick_res_t expected_ticks [$];
	int errors;
	int idle_cycles;
	int live_cnt;
	logic live [MAX_PROCS];

	task automatic report(input string what);
		errors++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	function automatic void sched_reset();
		now = 0;
		for (int l = 0; l < LEVELS; l++) lq[l].delete();
		n_ready = 0; running = 0; run_pid = 0; run_lvl = 0; run_left = 0; mode = 0;
		for (int i = 0; i < MAX_PROCS; i++) live[i] = 0;
		live_cnt = 0;
	endfunction

	function automatic void sched_arrive(input logic [4:0] pid, input logic [15:0] svc);
		if (svc == 0 || lq[0].size() >= MAX_PROCS) return;
		rem_t[pid] = svc; svc_len[pid] = svc; stamp[pid] = now;
		lq[0].insert(lq[0].size(), pid);
		n_ready++;
	endfunction

	function automatic tick_res_t sched_tick();
		tick_res_t r;
		int l;
		logic [4:0] f;
		r = '0;
		if (!running) begin
			for (l = 0; l < LEVELS; l++) if (lq[l].size() != 0) break;
			if (l >= LEVELS) begin
				now++;
				r.ftime = now;
				return r;
			end
			if (l == 0 && lq[0].size() > 1) begin
				f = lq[0][0];
				if (rem_t[f] < svc_len[f]) lq[0] = {lq[0][1:$], f};
			end
			run_pid = lq[l].pop_front();
			run_lvl = l;
			run_left = mode ? (1 << l) : 1;
			running = 1;
		end
		if (rem_t[run_pid] > 0) rem_t[run_pid]--;
		now++;
		run_left--;
		r.busy = 1; r.pid = run_pid; r.lvl = run_lvl[2:0]; r.ftime = now;
		if (rem_t[run_pid] == 0) begin
			r.done = 1;
			r.tat = now - stamp[run_pid];
			if (n_ready > 0) n_ready--;
			running = 0;
			if (live[run_pid]) begin
				live[run_pid] = 0;
				live_cnt--;
			end
		end else if (run_left == 0) begin
			running = 0;
			if (n_ready == 1 || run_lvl + 1 >= LEVELS || lq[run_lvl + 1].size() >= MAX_PROCS) begin
				if (lq[run_lvl].size() < MAX_PROCS)
					lq[run_lvl].insert(lq[run_lvl].size(), run_pid);
			end else
				lq[run_lvl + 1].insert(lq[run_lvl + 1].size(), run_pid);
		end
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver stall pattern
	int stall_phase;
	always @(negedge clk) begin
		stall_phase <= stall_phase + 1;
		case ((stall_phase / 200) % 3)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(3) != 0);
			default: m_tready <= ($urandom_range(2) == 0);
		endcase
	end

	// result checker
	always @(posedge clk) begin
		tick_res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = tick_res_t'(m_tdata[73:0]);
			if (expected_ticks.size() == 0) report("tick result with none expected");
			else begin
				want = expected_ticks.pop_front();
				if (got.busy !== want.busy) report($sformatf("cpu_busy %b exp %b", got.busy, want.busy));
				if (got.pid !== want.pid) report($sformatf("running_id %0d exp %0d", got.pid, want.pid));
				if (got.lvl !== want.lvl) report($sformatf("run_level %0d exp %0d", got.lvl, want.lvl));
				if (got.done !== want.done) report($sformatf("finished %b exp %b", got.done, want.done));
				if (got.ftime !== want.ftime)
					report($sformatf("finish_time %0d exp %0d", got.ftime, want.ftime));
				if (got.tat !== want.tat)
					report($sformatf("turnaround %0d exp %0d", got.tat, want.tat));
			end
		end
	end

	// watchdog on request, result and config handshakes
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// valid stays high after acceptance so the next call can follow back to back
	task automatic send_request(input stim_t st);
		tick_res_t r;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= st.kind;
		s_tdata <= {3'b0, st.svc, st.pid};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (st.kind == REQ_TICK) begin
			r = sched_tick();
			if (st.has_exp && r !== st.exp) report("directed row differs from predictor");
			expected_ticks.insert(expected_ticks.size(), st.has_exp ? st.exp : r);
		end else begin
			sched_arrive(st.pid, st.svc);
		end
	endtask

	task automatic stop_send();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// burst sender: holds valid across items inside a burst
	int burst_left;
	task automatic send_item(input stim_t st);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(6);
			if (gap != 0) begin
				stop_send();
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		send_request(st);
	endtask

	task automatic write_mode(input logic m);
		stop_send();
		while (expected_ticks.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		mode = m;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic stim_t mk(input logic k, input int pid, input int svc);
		stim_t s;
		s.kind = k; s.pid = pid[4:0]; s.svc = svc[15:0]; s.has_exp = 0; s.exp = '0;
		return s;
	endfunction

	function automatic stim_t random_item(input int tick_pct);
		stim_t s;
		int p;
		if (live_cnt >= 30 || $urandom_range(99) < tick_pct) return mk(REQ_TICK, 0, 0);
		s = mk(REQ_ARRIVE, 0, 0);
		// pick a free id so live ids are not reused
		p = $urandom_range(31);
		while (live[p]) p = (p + 1) % 32;
		s.pid = p[4:0];
		case ($urandom_range(9))
			0: s.svc = 16'hFFFF;
			1: s.svc = 0;
			2: s.svc = 16'($urandom);
			default: s.svc = 16'($urandom_range(1, 12));
		endcase
		if (s.svc != 0) begin
			live[p] = 1;
			live_cnt++;
		end
		return s;
	endfunction

	stim_t dir_rows [$];

	initial begin
		stim_t s;
		tick_res_t e;
		errors = 0; idle_cycles = 0; stall_phase = 0; burst_left = 0;
		arst_n = 0; cfg_valid = 0; cfg_data = 0; s_tvalid = 0; s_tdata = '0; s_tuser = '0;
		m_tready = 0;
		sched_reset();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// idle tick right after reset
		s = mk(REQ_TICK, 0, 0); s.has_exp = 1; e = '0; e.ftime = 1; s.exp = e;
		dir_rows.insert(dir_rows.size(), s);
		// zero service is ignored
		dir_rows.insert(dir_rows.size(), mk(REQ_ARRIVE, 3, 0));
		s = mk(REQ_TICK, 0, 0); s.has_exp = 1; e = '0; e.ftime = 2; s.exp = e;
		dir_rows.insert(dir_rows.size(), s);
		// one-tick process at highest id, completes at once
		dir_rows.insert(dir_rows.size(), mk(REQ_ARRIVE, 31, 1));
		s = mk(REQ_TICK, 0, 0); s.has_exp = 1;
		e = '0; e.busy = 1; e.pid = 31; e.done = 1; e.ftime = 3; e.tat = 1; s.exp = e;
		dir_rows.insert(dir_rows.size(), s);
		// three processes sharing, with demotion to lower levels
		dir_rows.insert(dir_rows.size(), mk(REQ_ARRIVE, 0, 3));
		dir_rows.insert(dir_rows.size(), mk(REQ_ARRIVE, 7, 2));
		for (int i = 0; i < 3; i++) dir_rows.insert(dir_rows.size(), mk(REQ_TICK, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(REQ_ARRIVE, 9, 2));
		for (int i = 0; i < 5; i++) dir_rows.insert(dir_rows.size(), mk(REQ_TICK, 0, 0));
		foreach (dir_rows[i]) send_request(dir_rows[i]);

		// max service, slice of 2^level
		write_mode(1);
		live[5] = 1; live_cnt++;
		send_request(mk(REQ_ARRIVE, 5, 16'hFFFF));
		send_request(mk(REQ_ARRIVE, 6, 4));
		live[6] = 1; live_cnt++;
		for (int i = 0; i < 4; i++) send_request(mk(REQ_TICK, 0, 0));

		// random phases, alternating mode; lots of ticks to drain long jobs
		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0) write_mode(ph % 2);
			for (int i = 0; i < 240; i++) send_item(random_item(ph % 2 ? 55 : 65));
		end

		stop_send();
		while (expected_ticks.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
